>>> src/rrs_pkg.sv
// Shared types, codes and reset constants of the round-robin slice scheduler.
package rrs_pkg;

  localparam int RRS_TABLE_SLOTS = 16;

  localparam logic [1:0] KIND_TICK = 2'd0;
  localparam logic [1:0] KIND_ADD  = 2'd1;
  localparam logic [1:0] KIND_SET  = 2'd2;

  localparam logic [1:0] ST_READY   = 2'd0;
  localparam logic [1:0] ST_RUNNING = 2'd1;
  localparam logic [1:0] ST_TERM    = 2'd3;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;
  localparam logic [1:0] STAT_NO_READY  = 2'd3;

  localparam logic [1:0] CFG_NORMAL_SLICE = 2'd0;
  localparam logic [1:0] CFG_KERNEL_FIRST = 2'd1;
  localparam logic [1:0] CFG_KERNEL_ID    = 2'd2;

  localparam logic [15:0] NORMAL_SLICE_RST = 16'd10;
  localparam logic [15:0] KERNEL_FIRST_RST = 16'd5;
  localparam logic [15:0] KERNEL_ID_RST    = 16'd0;

  typedef struct packed {
    logic [15:0] normal_slice;
    logic [15:0] kernel_first_slice;
    logic [15:0] kernel_id;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] proc_id;
    logic        use_current;
    logic [1:0]  new_state;
    logic [15:0] new_slice;
    logic        keep_slice;
  } cmd_t;

  typedef struct packed {
    logic [15:0] current_id;
    logic        switched;
    logic [1:0]  status;
    logic [31:0] tick_count;
    logic [15:0] slice_left;
  } res_t;

endpackage

>>> src/rrs_table.sv
// Slot table memory: one write port, one registered read port.
module rrs_table #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 39,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/rrs_ctrl.sv
// Scheduler sequencer: tick, add and set commands as read-modify-write walks of the slot table.
module rrs_ctrl #(
  parameter int TABLE_SLOTS = 16,
  parameter int SW = $clog2(TABLE_SLOTS),
  parameter int LW = $clog2(TABLE_SLOTS + 1),
  parameter int W  = 34 + LW
) (
  input  logic                 clk,
  input  logic                 rst,
  input  rrs_pkg::cfg_t        cfg,
  input  logic                 kfs_load,
  input  logic [15:0]          kfs_data,
  input  logic                 cmd_valid,
  output logic                 cmd_ready,
  input  rrs_pkg::cmd_t        cmd,
  output logic                 res_valid,
  input  logic                 res_take,
  output rrs_pkg::res_t        res,
  output logic                 mem_we,
  output logic [SW-1:0]        mem_waddr,
  output logic [W-1:0]         mem_wdata,
  output logic [SW-1:0]        mem_raddr,
  input  logic [W-1:0]         mem_rdata
);
  import rrs_pkg::*;

  localparam int CW = $clog2(TABLE_SLOTS + 1);
  localparam logic [LW-1:0] LINK_NULL = LW'(TABLE_SLOTS);

  typedef enum logic [4:0] {
    IDLE, TK_WT, TK_D, SL_WT, SL_D, SL_END, CR_WT, CR_D, FW,
    AD_SCAN, FD_WT, FD_D, ST_WT, ST_D, FIN, FIN_WT, FIN_D, DONE
  } state_t;

  state_t          state;
  cmd_t            c;
  logic [SW-1:0]   cur;
  logic [SW-1:0]   raddr;
  logic [SW-1:0]   prev_addr;
  logic [W-1:0]    prev_word;
  logic [SW-1:0]   found;
  logic [W-1:0]    found_word;
  logic            found_v;
  logic            cur_gone;
  logic [CW-1:0]   n;
  logic [SW-1:0]   scan;
  logic [31:0]     ticks;
  logic [TABLE_SLOTS-1:0] used;
  logic [1:0]      s0_state;
  logic [15:0]     s0_slice;
  logic [LW-1:0]   s0_link;
  logic            switched;
  logic [1:0]      status;

  // Slot zero lives in flip-flops so that it has a defined reset value.
  logic [W-1:0]    rdw;
  logic [15:0]     r_id;
  logic [1:0]      r_st;
  logic [15:0]     r_sl;
  logic [LW-1:0]   r_ln;
  logic [SW-1:0]   after;
  logic [15:0]     dec;
  logic            unl;
  logic            is_cur;
  logic            fd_hit;
  logic            w_en;
  logic [SW-1:0]   w_addr;
  logic [W-1:0]    w_data;

  assign rdw    = (raddr == '0) ? {cfg.kernel_id, s0_state, s0_slice, s0_link} : mem_rdata;
  assign r_id   = rdw[W-1:W-16];
  assign r_st   = rdw[LW+17:LW+16];
  assign r_sl   = rdw[LW+15:LW];
  assign r_ln   = rdw[LW-1:0];
  assign after  = (r_ln >= LINK_NULL) ? '0 : r_ln[SW-1:0];
  assign dec    = (r_sl == 16'd0) ? 16'd0 : r_sl - 16'd1;
  assign unl    = (r_st == ST_TERM) && (r_id != cfg.kernel_id);
  assign is_cur = (raddr == cur);
  assign fd_hit = used[raddr] && (r_id == c.proc_id);

  always_comb begin
    w_en   = 1'b0;
    w_addr = raddr;
    w_data = rdw;
    case (state)
      TK_D: begin
        w_en   = 1'b1;
        w_addr = cur;
        w_data = {r_id, r_st, dec, r_ln};
      end
      SL_D: begin
        if (unl) begin
          w_en   = 1'b1;
          w_addr = prev_addr;
          w_data = {prev_word[W-1:LW], r_ln};
        end
      end
      CR_D: begin
        w_en   = 1'b1;
        w_addr = cur;
        w_data = {r_id, ST_READY, r_sl, r_ln};
      end
      FW: begin
        w_en   = 1'b1;
        w_addr = found;
        w_data = {found_word[W-1:W-16], ST_RUNNING, cfg.normal_slice, found_word[LW-1:0]};
      end
      AD_SCAN: begin
        if (!used[scan]) begin
          w_en   = 1'b1;
          w_addr = scan;
          w_data = {c.proc_id, c.new_state, c.new_slice, s0_link};
        end
      end
      FD_D, ST_D: begin
        if (state == ST_D || fd_hit) begin
          w_en   = 1'b1;
          w_data = {r_id, c.new_state, c.keep_slice ? r_sl : c.new_slice, r_ln};
        end
      end
      default: begin
        w_en = 1'b0;
      end
    endcase
  end

  assign mem_we    = w_en && (w_addr != '0);
  assign mem_waddr = w_addr;
  assign mem_wdata = w_data;
  assign mem_raddr = raddr;
  assign cmd_ready = (state == IDLE);
  assign res_valid = (state == DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      cur      <= '0;
      raddr    <= '0;
      ticks    <= '0;
      used     <= TABLE_SLOTS'(1);
      s0_state <= ST_READY;
      s0_slice <= KERNEL_FIRST_RST;
      s0_link  <= LINK_NULL;
      switched <= 1'b0;
      status   <= STAT_OK;
      found_v  <= 1'b0;
      cur_gone <= 1'b0;
    end else begin
      if (kfs_load && ticks == 32'd0) begin
        s0_slice <= kfs_data;
      end
      if (w_en && w_addr == '0) begin
        s0_state <= w_data[LW+17:LW+16];
        s0_slice <= w_data[LW+15:LW];
        s0_link  <= w_data[LW-1:0];
      end
      case (state)
        IDLE: begin
          if (cmd_valid) begin
            c        <= cmd;
            switched <= 1'b0;
            status   <= STAT_OK;
            case (cmd.kind)
              KIND_TICK: begin
                ticks <= ticks + 32'd1;
                raddr <= cur;
                state <= TK_WT;
              end
              KIND_ADD: begin
                scan  <= '0;
                state <= AD_SCAN;
              end
              KIND_SET: begin
                if (cmd.use_current) begin
                  raddr <= cur;
                  state <= ST_WT;
                end else begin
                  raddr <= '0;
                  n     <= '0;
                  state <= FD_WT;
                end
              end
              default: begin
                state <= FIN;
              end
            endcase
          end
        end
        TK_WT: state <= TK_D;
        TK_D: begin
          if (dec == 16'd0) begin
            prev_addr <= cur;
            prev_word <= {r_id, r_st, dec, r_ln};
            raddr     <= after;
            n         <= '0;
            cur_gone  <= 1'b0;
            found_v   <= 1'b0;
            state     <= SL_WT;
          end else begin
            state <= FIN;
          end
        end
        SL_WT: state <= SL_D;
        SL_D: begin
          if (unl) begin
            // unlink: predecessor now skips this slot
            prev_word[LW-1:0] <= r_ln;
            used[raddr]       <= 1'b0;
            if (is_cur) begin
              cur_gone <= 1'b1;
              state    <= SL_END;
            end else if (n == CW'(TABLE_SLOTS)) begin
              state <= SL_END;
            end else begin
              n     <= n + CW'(1);
              raddr <= after;
              state <= SL_WT;
            end
          end else if (r_st == ST_READY) begin
            found_v    <= 1'b1;
            found      <= raddr;
            found_word <= rdw;
            state      <= SL_END;
          end else if (is_cur || n == CW'(TABLE_SLOTS)) begin
            state <= SL_END;
          end else begin
            prev_addr <= raddr;
            prev_word <= rdw;
            n         <= n + CW'(1);
            raddr     <= after;
            state     <= SL_WT;
          end
        end
        SL_END: begin
          if (!found_v) begin
            status <= STAT_NO_READY;
            if (cur_gone) begin
              cur      <= '0;
              switched <= 1'b1;
            end
            state <= FIN;
          end else if (found == cur) begin
            state <= FIN;
          end else begin
            raddr <= cur;
            state <= CR_WT;
          end
        end
        CR_WT: state <= CR_D;
        CR_D:  state <= FW;
        FW: begin
          cur      <= found;
          switched <= 1'b1;
          state    <= FIN;
        end
        AD_SCAN: begin
          if (!used[scan]) begin
            used[scan] <= 1'b1;
            s0_link    <= LW'(scan);
            state      <= FIN;
          end else if (scan == SW'(TABLE_SLOTS - 1)) begin
            status <= STAT_FULL;
            state  <= FIN;
          end else begin
            scan <= scan + SW'(1);
          end
        end
        FD_WT: state <= FD_D;
        FD_D: begin
          if (fd_hit) begin
            state <= FIN;
          end else if (r_ln >= LINK_NULL || n == CW'(TABLE_SLOTS - 1)) begin
            status <= STAT_NOT_FOUND;
            state  <= FIN;
          end else begin
            n     <= n + CW'(1);
            raddr <= r_ln[SW-1:0];
            state <= FD_WT;
          end
        end
        ST_WT: state <= ST_D;
        ST_D:  state <= FIN;
        FIN: begin
          raddr <= cur;
          state <= FIN_WT;
        end
        FIN_WT: state <= FIN_D;
        FIN_D: begin
          res.current_id <= r_id;
          res.switched   <= switched;
          res.status     <= status;
          res.tick_count <= ticks;
          res.slice_left <= r_sl;
          state          <= DONE;
        end
        DONE: begin
          if (res_take) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

>>> src/round_robin_slice_scheduler.sv
// Top level of the round-robin slice scheduler: config registers, output register, table.
//
// Usage: commands arrive on the s_ stream (s_tuser = kind: tick, add, set);
// each produces exactly one result transfer on the m_ stream, in order.
// Configuration is written through cfg_we / cfg_index / cfg_wdata while idle.
// A tick that leaves slice left, a set on the current task and the unused kind
// touch only the current slot. A tick that ends a slice walks the slots
// (up to TABLE_SLOTS + 1) and, when it switches, rewrites the old and new
// current slot; a set by id searches up to TABLE_SLOTS slots; an add scans
// the used bits.
// Throughput is one command at a time; the walks over the slot table memory
// set the figure, and the next command is taken as its result leaves.
// Reset (rst, synchronous) leaves only the kernel task in slot zero, head
// and current, with its first slice; no clearing pass is needed.
// The result sits in an output register: a stalled receiver holds it, and
// the next command is still taken and worked on meanwhile; its own result
// then waits until the register frees up.
module round_robin_slice_scheduler #(
  parameter int TABLE_SLOTS = rrs_pkg::RRS_TABLE_SLOTS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [15:0] proc_id, [16] use_current, [18:17] new_state, [34:19] new_slice,
  // [35] keep_slice, [39:36] zero
  input  logic [39:0] s_tdata,
  // [1:0] kind
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [15:0] current_id, [16] switched, [18:17] status, [50:19] tick_count,
  // [66:51] slice_left, [71:67] zero
  output logic [71:0] m_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  import rrs_pkg::*;

  localparam int SW = $clog2(TABLE_SLOTS);
  localparam int LW = $clog2(TABLE_SLOTS + 1);
  localparam int W  = 34 + LW;

  cfg_t          cfg;
  cmd_t          cmd;
  res_t          res;
  logic          res_valid;
  logic          res_take;
  logic          kfs_load;
  logic          mem_we;
  logic [SW-1:0] mem_waddr;
  logic [W-1:0]  mem_wdata;
  logic [SW-1:0] mem_raddr;
  logic [W-1:0]  mem_rdata;

  // Config registers; writes beyond the register list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.normal_slice       <= NORMAL_SLICE_RST;
      cfg.kernel_first_slice <= KERNEL_FIRST_RST;
      cfg.kernel_id          <= KERNEL_ID_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NORMAL_SLICE: cfg.normal_slice       <= cfg_wdata;
        CFG_KERNEL_FIRST: cfg.kernel_first_slice <= cfg_wdata;
        CFG_KERNEL_ID:    cfg.kernel_id          <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // kernel_first_slice also reloads slot zero until the first tick
  assign kfs_load = cfg_we && (cfg_index == CFG_KERNEL_FIRST);

  assign cmd.kind        = s_tuser;
  assign cmd.proc_id     = s_tdata[15:0];
  assign cmd.use_current = s_tdata[16];
  assign cmd.new_state   = s_tdata[18:17];
  assign cmd.new_slice   = s_tdata[34:19];
  assign cmd.keep_slice  = s_tdata[35];

  // output register: loaded when empty or being drained this cycle
  assign res_take = res_valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      m_tdata <= {5'd0, res.slice_left, res.tick_count, res.status, res.switched,
                  res.current_id};
    end
  end

  rrs_ctrl #(
    .TABLE_SLOTS(TABLE_SLOTS),
    .SW(SW),
    .LW(LW),
    .W(W)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .kfs_load(kfs_load),
    .kfs_data(cfg_wdata),
    .cmd_valid(s_tvalid),
    .cmd_ready(s_tready),
    .cmd(cmd),
    .res_valid(res_valid),
    .res_take(res_take),
    .res(res),
    .mem_we(mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  rrs_table #(
    .DEPTH(TABLE_SLOTS),
    .WIDTH(W),
    .AW(SW)
  ) u_table (
    .clk(clk),
    .we(mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

endmodule
